// File: design/mbd_pkg.sv
// Shared constants and types for the mipmap box downsampler.
`timescale 1ns / 1ps

package mbd_pkg;

  // Default build parameters.
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int CHAN_BITS_DEF = 32;

  // Fixed geometry of the ports.
  localparam int NUM_LANES      = 4;
  localparam int PORT_BITS      = 32;
  localparam int SRC_WIDTH_BITS = 13;
  localparam int NUM_CH_BITS    = 3;
  localparam int CFG_IDX_BITS   = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH    = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_CHANNELS = 1'd1;

  // Register reset values.
  localparam logic [SRC_WIDTH_BITS-1:0] SRC_WIDTH_RST    = 13'd2;
  localparam logic [NUM_CH_BITS-1:0]    NUM_CHANNELS_RST = 3'd4;

  // Line store command for one accepted item.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

// File: design/mbd_lane.sv
// One channel lane: horizontal pair average and vertical merge average.
`timescale 1ns / 1ps

module mbd_lane #(
  parameter int CHAN_BITS = mbd_pkg::CHAN_BITS_DEF
) (
  input  logic [CHAN_BITS-1:0] left_px,
  input  logic [CHAN_BITS-1:0] px,
  output logic [CHAN_BITS-1:0] pair_avg,
  input  logic [CHAN_BITS-1:0] stored_avg,
  input  logic [CHAN_BITS-1:0] held_avg,
  input  logic                 lane_en,
  output logic [CHAN_BITS-1:0] result
);

  logic [CHAN_BITS:0] pair_sum;
  logic [CHAN_BITS:0] merge_sum;

  // Sums keep the carry bit, so the floored average never wraps.
  assign pair_sum  = (CHAN_BITS+1)'(left_px) + (CHAN_BITS+1)'(px);
  assign pair_avg  = pair_sum[CHAN_BITS:1];

  assign merge_sum = (CHAN_BITS+1)'(stored_avg) + (CHAN_BITS+1)'(held_avg);
  assign result    = lane_en ? merge_sum[CHAN_BITS:1] : '0;

endmodule

// File: design/mbd_line_store.sv
// Line store holding the pair averages of the last even source row.
`timescale 1ns / 1ps

module mbd_line_store #(
  parameter int DEPTH = mbd_pkg::MAX_WIDTH_DEF / 2,
  parameter int AW    = 11,
  parameter int DW    = 128
) (
  input  logic                   clk,
  input  mbd_pkg::store_ctl_t    ctl,
  input  logic [AW-1:0]          addr,
  input  logic [DW-1:0]          wdata,
  output logic [DW-1:0]          rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/mipmap_box_downsample.sv
// Top level of the 2x2 box-filter mipmap downsampler.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready   in_ch0..in_ch3, in_start_image
//   out_     output     out_valid / out_ready out_ch0..out_ch3, out_row_end
//   cfg_     input      cfg_we                cfg_index, cfg_data
//
// One pixel item is accepted every cycle when the output side keeps up.
// A result follows the item that completes a 2x2 block through the line store
// read stage and then the merge stage.
// The line store is one single-port memory; a row only writes it or only
// reads it, so one port serves each accepted item.
// Reset (synchronous, rst_n low) clears the counters, the left-pixel hold,
// the pipeline valids and the configuration registers; the line store is not cleared.
// A stalled output holds the merge register and the read stage; input is
// still taken while either of the two pipeline stages has room.
`timescale 1ns / 1ps

module mipmap_box_downsample #(
  parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF,
  parameter int CHAN_BITS = mbd_pkg::CHAN_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mbd_pkg::PORT_BITS-1:0]        in_ch0,
  input  logic [mbd_pkg::PORT_BITS-1:0]        in_ch1,
  input  logic [mbd_pkg::PORT_BITS-1:0]        in_ch2,
  input  logic [mbd_pkg::PORT_BITS-1:0]        in_ch3,
  input  logic                                 in_start_image,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mbd_pkg::PORT_BITS-1:0]        out_ch0,
  output logic [mbd_pkg::PORT_BITS-1:0]        out_ch1,
  output logic [mbd_pkg::PORT_BITS-1:0]        out_ch2,
  output logic [mbd_pkg::PORT_BITS-1:0]        out_ch3,
  output logic                                 out_row_end,

  input  logic                                 cfg_we,
  input  logic [mbd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mbd_pkg::SRC_WIDTH_BITS-1:0]   cfg_data
);

  localparam int NL    = mbd_pkg::NUM_LANES;
  localparam int HALF  = MAX_WIDTH / 2;
  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW    = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int DW    = NL * CHAN_BITS;

  // Configuration registers.
  logic [mbd_pkg::SRC_WIDTH_BITS-1:0] src_width_r;
  logic [mbd_pkg::NUM_CH_BITS-1:0]    num_channels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r    <= mbd_pkg::SRC_WIDTH_RST;
      num_channels_r <= mbd_pkg::NUM_CHANNELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbd_pkg::REG_SRC_WIDTH:    src_width_r    <= cfg_data;
        mbd_pkg::REG_NUM_CHANNELS: num_channels_r <= cfg_data[mbd_pkg::NUM_CH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective width is the register clamped to [2, MAX_WIDTH]. From it come
  // the last column index and the last output slot of a row.
  logic [31:0]                     src32;
  logic [31:0]                     eff32;
  logic [CW-1:0]                   last_col;
  logic [SW-1:0]                   last_slot;
  logic [mbd_pkg::NUM_CH_BITS-1:0] nch;
  logic [NL-1:0]                   lane_en;

  always_comb begin
    src32 = 32'(src_width_r);
    if (src32 < 32'd2) begin
      eff32 = 32'd2;
    end else if (src32 > 32'(MAX_WIDTH)) begin
      eff32 = 32'(MAX_WIDTH);
    end else begin
      eff32 = src32;
    end
    last_col  = CW'(eff32 - 32'd1);
    last_slot = SW'((eff32 >> 1) - 32'd1);
    // Channel counts above the lane count act as all lanes on.
    nch = (num_channels_r > mbd_pkg::NUM_CH_BITS'(NL)) ?
          mbd_pkg::NUM_CH_BITS'(NL) : num_channels_r;
  end

  for (genvar g = 0; g < NL; g++) begin : g_en
    assign lane_en[g] = (mbd_pkg::NUM_CH_BITS'(g) < nch);
  end

  // Raster position.
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic          odd_row_r, odd_row_nxt;
  logic [CW-1:0] col_base;
  logic          odd_base;
  logic [CW-1:0] col;
  logic [SW-1:0] slot;
  logic          row_last;
  logic          in_fire;
  logic          produces;
  mbd_pkg::store_ctl_t store_ctl;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    // A start-of-image item is column 0 of an even row.
    col_base = in_start_image ? '0 : col_cnt_r;
    odd_base = in_start_image ? 1'b0 : odd_row_r;
    // A width that shrank mid-row ends the row at once.
    col      = (col_base > last_col) ? last_col : col_base;
    slot     = SW'(col >> 1);
    row_last = (col == last_col);
    produces = col[0] && odd_base;
    store_ctl.wr_en = in_fire && col[0] && !odd_base;
    store_ctl.rd_en = in_fire && produces;
    col_cnt_nxt = row_last ? '0 : col + CW'(1);
    odd_row_nxt = odd_base ^ row_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      odd_row_r <= 1'b0;
    end else if (in_fire) begin
      col_cnt_r <= col_cnt_nxt;
      odd_row_r <= odd_row_nxt;
    end
  end

  // Input pixel lanes, cut to the channel width.
  logic [CHAN_BITS-1:0] px       [NL];
  logic [CHAN_BITS-1:0] left_r   [NL];
  logic [CHAN_BITS-1:0] pair_avg [NL];
  logic [CHAN_BITS-1:0] held_r   [NL];
  logic [CHAN_BITS-1:0] stored   [NL];
  logic [CHAN_BITS-1:0] result   [NL];
  logic [DW-1:0]        store_wdata;
  logic [DW-1:0]        store_rdata;

  assign px[0] = in_ch0[CHAN_BITS-1:0];
  assign px[1] = in_ch1[CHAN_BITS-1:0];
  assign px[2] = in_ch2[CHAN_BITS-1:0];
  assign px[3] = in_ch3[CHAN_BITS-1:0];

  for (genvar g = 0; g < NL; g++) begin : g_lane
    mbd_lane #(
      .CHAN_BITS (CHAN_BITS)
    ) u_lane (
      .left_px    (left_r[g]),
      .px         (px[g]),
      .pair_avg   (pair_avg[g]),
      .stored_avg (stored[g]),
      .held_avg   (held_r[g]),
      .lane_en    (lane_en[g]),
      .result     (result[g])
    );
    assign store_wdata[g*CHAN_BITS +: CHAN_BITS] = pair_avg[g];
    assign stored[g] = store_rdata[g*CHAN_BITS +: CHAN_BITS];
  end

  // The left pixel of each pair waits here for its right neighbor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NL; i++) begin
        left_r[i] <= '0;
      end
    end else if (in_fire && !col[0]) begin
      for (int i = 0; i < NL; i++) begin
        left_r[i] <= px[i];
      end
    end
  end

  mbd_line_store #(
    .DEPTH (HALF),
    .AW    (SW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .ctl   (store_ctl),
    .addr  (slot),
    .wdata (store_wdata),
    .rdata (store_rdata)
  );

  // Read stage: the odd-row pair average waits beside the line store read.
  logic s1_valid_r, s1_valid_nxt;
  logic s1_row_end_r;
  logic s1_move;
  logic out_valid_r, out_valid_nxt;
  logic out_row_end_r;
  logic [CHAN_BITS-1:0] out_data_r [NL];

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;

  always_comb begin
    priority if (in_fire) begin
      s1_valid_nxt = produces;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    priority if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_ctl.rd_en) begin
      s1_row_end_r <= (slot == last_slot);
      for (int i = 0; i < NL; i++) begin
        held_r[i] <= pair_avg[i];
      end
    end
    // Merge stage: the lanes' vertical averages become one output pixel.
    if (s1_move) begin
      out_row_end_r <= s1_row_end_r;
      for (int i = 0; i < NL; i++) begin
        out_data_r[i] <= result[i];
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row_end = out_row_end_r;
  assign out_ch0     = mbd_pkg::PORT_BITS'(out_data_r[0]);
  assign out_ch1     = mbd_pkg::PORT_BITS'(out_data_r[1]);
  assign out_ch2     = mbd_pkg::PORT_BITS'(out_data_r[2]);
  assign out_ch3     = mbd_pkg::PORT_BITS'(out_data_r[3]);

`ifndef NO_ASSERTIONS
  // Input is refused only when both pipeline stages are full.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r))
    else $error("input refused with room in the pipeline");

  // An item that completes a block always reaches the read stage.
  a_fire_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && produces) |=> s1_valid_r)
    else $error("completed block lost before the read stage");

  // A blocked read stage keeps its item and its row end flag.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |=> (s1_valid_r && $stable(s1_row_end_r)))
    else $error("read stage item dropped while blocked");

  // With zero channels enabled, output channel 0 gives zero.
  a_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (nch == '0)) |-> (out_ch0 == '0))
    else $error("disabled channel gave a nonzero value");
`endif

endmodule
